// File: src/rfhc_pkg.sv
// Shared types and constants for the RPC response frame header checker.
// Used by every module of the block and by its port checker; no dependencies.
package rfhc_pkg;

  // Frame layout.
  localparam logic [31:0] MAGIC_WORD       = 32'hAACC_33D5;
  localparam int          TYPE_LEN_LSB     = 5;
  localparam int          ID_LEN_LSB       = 2;
  localparam int          FRAME_HEAD_BYTES = 8;
  localparam int          RPC_FIXED_BYTES  = 9;

  // The byte count saturates at the top of this width.
  localparam int POS_W = 25;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Configuration register file.
  localparam int          CFG_DATA_W  = 64;
  localparam int          CFG_ADDR_W  = 4;
  localparam logic        REG_REQUEST_ID   = 1'b0;
  localparam logic        REG_MESSAGE_TYPE = 1'b1;
  localparam logic [63:0] REQUEST_ID_RESET   = 64'd0;
  localparam logic [63:0] MESSAGE_TYPE_RESET = 64'd90;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_TRUNCATED      = 3'd1,
    ST_BAD_VERSION    = 3'd2,
    ST_BAD_MAGIC      = 3'd3,
    ST_LENGTH_MISMATCH = 3'd4,
    ST_ID_MISMATCH    = 3'd5,
    ST_TYPE_MISMATCH  = 3'd6
  } status_t;

  // One received byte held in the input register.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } beat_t;

  // One result; status sits in the lowest bits once packed.
  typedef struct packed {
    logic [23:0] message_size;
    logic [63:0] request_id;
    logic [63:0] message_type;
    logic [4:0]  header_length;
    status_t     status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// File: src/rpc_frame_header_checker.sv
// RPC response frame header checker, top level.
// A final byte's result passes through the input register, then the result
// register; other bytes give no result.
// Throughput: one byte per cycle; a final byte waits only while the previous
// result is still unread in the result register.
// Reset (rst, synchronous): clears frame state, empties both registers and
// restores expected request id 0 and expected message type 90.
module rpc_frame_header_checker (
  input  logic                              clk,
  input  logic                              rst,
  // Byte stream in. tdata: [7:0] data_byte; tlast: end_of_frame.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  input  logic                              s_axis_tlast,
  // Results out. tdata: [2:0] status, [7:3] header_length,
  // [71:8] message_type, [135:72] request_id, [159:136] message_size.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rfhc_pkg::RESULT_W-1:0]     m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rfhc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rfhc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rfhc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic              beat_valid;
  rfhc_pkg::beat_t   beat;
  logic              beat_take;
  logic              out_busy;
  logic              res_valid;
  rfhc_pkg::result_t res;
  logic [63:0]       expected_request_id;
  logic [63:0]       expected_message_type;

  rfhc_cfg_regs u_cfg_regs (
    .clk                   (clk),
    .rst                   (rst),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .expected_request_id   (expected_request_id),
    .expected_message_type (expected_message_type)
  );

  rfhc_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .beat_valid    (beat_valid),
    .beat          (beat),
    .beat_take     (beat_take)
  );

  rfhc_frame u_frame (
    .clk                   (clk),
    .rst                   (rst),
    .beat_valid            (beat_valid),
    .beat                  (beat),
    .beat_take             (beat_take),
    .out_busy              (out_busy),
    .expected_request_id   (expected_request_id),
    .expected_message_type (expected_message_type),
    .res_valid             (res_valid),
    .res                   (res)
  );

  rfhc_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .out_busy      (out_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: src/rfhc_cfg_regs.sv
// APB-style configuration registers: expected request id and message type.
// Depends on rfhc_pkg for the register map and reset values.
module rfhc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rfhc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rfhc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rfhc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [63:0]                       expected_request_id,
  output logic [63:0]                       expected_message_type
);

  logic wr_en;
  logic reg_sel;

  // Registers sit on 8-byte boundaries, so address bit 3 selects one.
  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes at the end of the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_request_id   <= rfhc_pkg::REQUEST_ID_RESET;
      expected_message_type <= rfhc_pkg::MESSAGE_TYPE_RESET;
    end else if (wr_en) begin
      if (reg_sel == rfhc_pkg::REG_MESSAGE_TYPE) begin
        expected_message_type <= pwdata;
      end else begin
        expected_request_id <= pwdata;
      end
    end
  end

  // Read-back of the selected register.
  assign prdata = (reg_sel == rfhc_pkg::REG_MESSAGE_TYPE) ? expected_message_type
                                                          : expected_request_id;

endmodule

// File: src/rfhc_in_reg.sv
// Input register for the byte stream, one byte deep.
// Depends on rfhc_pkg for the beat type.
module rfhc_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 beat_valid,
  output rfhc_pkg::beat_t      beat,
  input  logic                 beat_take
);

  // A new byte may enter whenever the held one is empty or leaves this cycle.
  assign s_axis_tready = !beat_valid || beat_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (s_axis_tready) begin
      beat_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      beat.data <= s_axis_tdata;
      beat.last <= s_axis_tlast;
    end
  end

endmodule

// File: src/rfhc_frame.sv
// Frame state and header checks: folds one byte per cycle into the header
// fields (a final byte waits behind an unread result), builds the result on the final byte. Depends on rfhc_pkg.
module rfhc_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 beat_valid,
  input  rfhc_pkg::beat_t      beat,
  output logic                 beat_take,
  input  logic                 out_busy,
  input  logic [63:0]          expected_request_id,
  input  logic [63:0]          expected_message_type,
  output logic                 res_valid,
  output rfhc_pkg::result_t    res
);

  localparam int POS_W = rfhc_pkg::POS_W;

  // Frame state.
  logic [POS_W-1:0] byte_position;
  logic [31:0]      magic_shift;
  logic [7:0]       version_seen;
  logic [23:0]      size_accumulator;
  logic [3:0]       type_field_length;
  logic [3:0]       id_field_length;
  logic [63:0]      type_accumulator;
  logic [63:0]      id_accumulator;

  logic [POS_W-1:0] byte_position_next;
  logic [31:0]      magic_shift_next;
  logic [7:0]       version_seen_next;
  logic [23:0]      size_accumulator_next;
  logic [3:0]       type_field_length_next;
  logic [3:0]       id_field_length_next;
  logic [63:0]      type_accumulator_next;
  logic [63:0]      id_accumulator_next;

  logic [POS_W-1:0] pos;
  logic [7:0]       b;
  logic [POS_W-1:0] type_start;
  logic [POS_W-1:0] type_end;
  logic [POS_W-1:0] id_end;
  logic [POS_W-1:0] type_off;
  logic [POS_W-1:0] id_off;
  logic [1:0]       size_lane;
  logic [4:0]       hl;
  logic             have_fields;
  logic             n_ge_fixed;
  rfhc_pkg::status_t status;

  // A final byte waits while the previous result is still unread.
  assign beat_take = beat_valid && !(beat.last && out_busy);
  assign res_valid = beat_take && beat.last;

  assign pos        = byte_position;
  assign b          = beat.data;
  assign type_start = POS_W'(rfhc_pkg::RPC_FIXED_BYTES);
  assign type_end   = type_start + POS_W'(type_field_length);
  assign id_end     = type_end + POS_W'(id_field_length);
  assign type_off   = pos - type_start;
  assign id_off     = pos - type_end;
  assign size_lane  = pos[1:0] - 2'd1;

  // Fold the current byte into the field it belongs to.
  always_comb begin
    byte_position_next     = (pos == rfhc_pkg::POS_MAX) ? pos : pos + POS_W'(1);
    magic_shift_next       = magic_shift;
    version_seen_next      = version_seen;
    size_accumulator_next  = size_accumulator;
    type_field_length_next = type_field_length;
    id_field_length_next   = id_field_length;
    type_accumulator_next  = type_accumulator;
    id_accumulator_next    = id_accumulator;
    if (pos == '0) begin
      version_seen_next = b;
    end else if (pos < POS_W'(4)) begin
      size_accumulator_next[{size_lane, 3'b000} +: 8] = b;
    end else if (pos < POS_W'(rfhc_pkg::FRAME_HEAD_BYTES)) begin
      magic_shift_next[{pos[1:0], 3'b000} +: 8] = b;
    end else if (pos == POS_W'(rfhc_pkg::FRAME_HEAD_BYTES)) begin
      type_field_length_next = {1'b0, b[rfhc_pkg::TYPE_LEN_LSB +: 3]} + 4'd1;
      id_field_length_next   = {1'b0, b[rfhc_pkg::ID_LEN_LSB +: 3]} + 4'd1;
    end else if (pos < type_end) begin
      type_accumulator_next[{type_off[2:0], 3'b000} +: 8] = b;
    end else if (pos < id_end) begin
      id_accumulator_next[{id_off[2:0], 3'b000} +: 8] = b;
    end
  end

  // Header length and whether the variable header arrived in full.
  assign n_ge_fixed = byte_position_next >= POS_W'(rfhc_pkg::RPC_FIXED_BYTES);
  assign hl = n_ge_fixed ? (5'(rfhc_pkg::RPC_FIXED_BYTES) + {1'b0, type_field_length_next}
                            + {1'b0, id_field_length_next}) : 5'd0;
  assign have_fields = n_ge_fixed && (byte_position_next >= POS_W'(hl));

  // The first failing check decides: short head, version, magic, short header, length, request id, type.
  always_comb begin
    if (byte_position_next < POS_W'(rfhc_pkg::FRAME_HEAD_BYTES)) begin
      status = rfhc_pkg::ST_TRUNCATED;
    end else if (version_seen_next != 8'd0) begin
      status = rfhc_pkg::ST_BAD_VERSION;
    end else if (magic_shift_next != rfhc_pkg::MAGIC_WORD) begin
      status = rfhc_pkg::ST_BAD_MAGIC;
    end else if (!have_fields) begin
      status = rfhc_pkg::ST_TRUNCATED;
    end else if (byte_position_next != (POS_W'(rfhc_pkg::FRAME_HEAD_BYTES)
                                        + POS_W'(size_accumulator_next))) begin
      status = rfhc_pkg::ST_LENGTH_MISMATCH;
    end else if (id_accumulator_next != expected_request_id) begin
      status = rfhc_pkg::ST_ID_MISMATCH;
    end else if (type_accumulator_next != expected_message_type) begin
      status = rfhc_pkg::ST_TYPE_MISMATCH;
    end else begin
      status = rfhc_pkg::ST_OK;
    end
  end

  // Result fields; a field that did not arrive in full reads as zero.
  always_comb begin
    res.status        = status;
    res.header_length = hl;
    res.message_type  = have_fields ? type_accumulator_next : 64'd0;
    res.request_id    = have_fields ? id_accumulator_next : 64'd0;
    res.message_size  = (byte_position_next >= POS_W'(4)) ? size_accumulator_next : 24'd0;
  end

  // State update; the final byte returns the frame state to its reset values.
  always_ff @(posedge clk) begin
    if (rst || (beat_take && beat.last)) begin
      byte_position     <= '0;
      magic_shift       <= '0;
      version_seen      <= '0;
      size_accumulator  <= '0;
      type_field_length <= '0;
      id_field_length   <= '0;
      type_accumulator  <= '0;
      id_accumulator    <= '0;
    end else if (beat_take) begin
      byte_position     <= byte_position_next;
      magic_shift       <= magic_shift_next;
      version_seen      <= version_seen_next;
      size_accumulator  <= size_accumulator_next;
      type_field_length <= type_field_length_next;
      id_field_length   <= id_field_length_next;
      type_accumulator  <= type_accumulator_next;
      id_accumulator    <= id_accumulator_next;
    end
  end

endmodule

// File: src/rfhc_out_reg.sv
// Result register on the output stream; holds a result until it is taken.
// Depends on rfhc_pkg for the result type.
module rfhc_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           res_valid,
  input  rfhc_pkg::result_t              res,
  output logic                           out_busy,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rfhc_pkg::RESULT_W-1:0]  m_axis_tdata
);

  rfhc_pkg::result_t held;

  // The register is busy while it holds a result that is not taken this cycle.
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

  assign m_axis_tdata = held;

endmodule

// File: src/rfhc_checker.sv
// Port-level checks for the RPC frame header checker, bound to its top level.
// Depends on rfhc_pkg for the status codes and result width.
module rfhc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rfhc_pkg::RESULT_W-1:0]  m_axis_tdata
);

  logic [2:0] st;
  logic [4:0] hl;

  assign st = m_axis_tdata[2:0];
  assign hl = m_axis_tdata[7:3];

  // Reset empties the result register.
  a_reset_empties: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result still valid after reset");

  // A stalled result holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The input only stalls behind an unread result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // A status past the truncation check implies a complete header length.
  a_header_seen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (st == rfhc_pkg::ST_OK || st == rfhc_pkg::ST_LENGTH_MISMATCH ||
                      st == rfhc_pkg::ST_ID_MISMATCH || st == rfhc_pkg::ST_TYPE_MISMATCH)
    |-> hl >= 5'd11 && hl <= 5'd25)
    else $error("status implies a header that was not seen");

endmodule

bind rpc_frame_header_checker rfhc_checker u_rfhc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: test/tb_rpc_frame_header_checker.sv
// Self-checking testbench for the RPC response frame header checker.
// Depends on rfhc_pkg and rpc_frame_header_checker; predicts each result from its own frame model.
`timescale 1ns / 100ps

module tb_rpc_frame_header_checker;

  // Cycles with no transaction on any port before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  // Bytes to send over the whole run; random frames top up what the directed tests leave.
  localparam int ITEM_TARGET = 400;
  localparam logic [rfhc_pkg::CFG_ADDR_W-1:0] ADDR_REQUEST_ID =
    {rfhc_pkg::REG_REQUEST_ID, 3'b000};
  localparam logic [rfhc_pkg::CFG_ADDR_W-1:0] ADDR_MESSAGE_TYPE =
    {rfhc_pkg::REG_MESSAGE_TYPE, 3'b000};

  typedef logic [7:0] frame_t[$];

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata = '0;   // [7:0] data_byte
  logic                            s_axis_tlast = 1'b0; // end_of_frame
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rfhc_pkg::RESULT_W-1:0]   m_axis_tdata;        // status, header_length, type, id, size
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [rfhc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [rfhc_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [rfhc_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  // Local copy of the registers and of the frame being parsed.
  logic [63:0]                even_unused_guard = '0;
  logic [63:0]                want_request_id = rfhc_pkg::REQUEST_ID_RESET;
  logic [63:0]                want_message_type = rfhc_pkg::MESSAGE_TYPE_RESET;
  logic [rfhc_pkg::POS_W-1:0] frame_pos = '0;
  logic [7:0]                 version_byte = '0;
  logic [23:0]                size_field = '0;
  logic [31:0]                magic_field = '0;
  int                         type_len = 0;
  int                         id_len = 0;
  logic [63:0]                type_value = '0;
  logic [63:0]                id_value = '0;

  rfhc_pkg::result_t pending_results[$];
  int                error_count = 0;
  int                bytes_sent = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  int                rx_mode = 0;
  int                rx_left = 0;

  rpc_frame_header_checker u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock generation.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fold one accepted byte into the frame model; a final byte yields the expected result.
  function automatic void absorb_frame_byte(input logic [7:0] b, input logic last);
    int                pos;
    int                n;
    int                off;
    int                hl;
    bit                fields_seen;
    rfhc_pkg::result_t r;
    pos = int'(frame_pos);
    if (pos == 0) begin
      version_byte = b;
    end else if (pos < 4) begin
      size_field[8*(pos-1) +: 8] = b;
    end else if (pos < rfhc_pkg::FRAME_HEAD_BYTES) begin
      magic_field[8*(pos-4) +: 8] = b;
    end else if (pos == rfhc_pkg::FRAME_HEAD_BYTES) begin
      type_len = 1 + ((b >> rfhc_pkg::TYPE_LEN_LSB) & 7);
      id_len   = 1 + ((b >> rfhc_pkg::ID_LEN_LSB) & 7);
    end else begin
      off = pos - rfhc_pkg::RPC_FIXED_BYTES;
      if (off < type_len) begin
        type_value[8*off +: 8] = b;
      end else if (off - type_len < id_len) begin
        id_value[8*(off-type_len) +: 8] = b;
      end
    end
    if (frame_pos != rfhc_pkg::POS_MAX) frame_pos = frame_pos + 1'b1;
    if (!last) return;

    // Work out the result; the first failing check decides the status.
    n  = int'(frame_pos);
    hl = (n >= rfhc_pkg::RPC_FIXED_BYTES) ? rfhc_pkg::RPC_FIXED_BYTES + type_len + id_len : 0;
    fields_seen = (n >= rfhc_pkg::RPC_FIXED_BYTES) && (n >= hl);
    if (n < rfhc_pkg::FRAME_HEAD_BYTES) r.status = rfhc_pkg::ST_TRUNCATED;
    else if (version_byte != 8'd0) r.status = rfhc_pkg::ST_BAD_VERSION;
    else if (magic_field != rfhc_pkg::MAGIC_WORD) r.status = rfhc_pkg::ST_BAD_MAGIC;
    else if (!fields_seen) r.status = rfhc_pkg::ST_TRUNCATED;
    else if (n != rfhc_pkg::FRAME_HEAD_BYTES + int'(size_field))
      r.status = rfhc_pkg::ST_LENGTH_MISMATCH;
    else if (id_value != want_request_id) r.status = rfhc_pkg::ST_ID_MISMATCH;
    else if (type_value != want_message_type) r.status = rfhc_pkg::ST_TYPE_MISMATCH;
    else r.status = rfhc_pkg::ST_OK;
    r.header_length = 5'(hl);
    r.message_type  = fields_seen ? type_value : 64'd0;
    r.request_id    = fields_seen ? id_value : 64'd0;
    r.message_size  = (n >= 4) ? size_field : 24'd0;
    pending_results.push_back(r);

    frame_pos    = '0;
    version_byte = '0;
    size_field   = '0;
    magic_field  = '0;
    type_len     = 0;
    id_len       = 0;
    type_value   = '0;
    id_value     = '0;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Keeps only the lowest count bytes of a value.
  function automatic logic [63:0] low_bytes(input logic [63:0] v, input int count);
    if (count >= 8) return v;
    return v & ((64'd1 << (8 * count)) - 64'd1);
  endfunction

  // Smallest field length in bytes that still holds the value.
  function automatic int bytes_needed(input logic [63:0] v);
    for (int l = 1; l < 8; l++) begin
      if ((v >> (8 * l)) == 64'd0) return l;
    end
    return 8;
  endfunction

  // A well-formed frame with a correct size field and random payload bytes.
  function automatic frame_t make_frame(input int tlen, input int ilen,
                                        input logic [63:0] tval, input logic [63:0] ival,
                                        input int payload);
    frame_t      f;
    logic [23:0] size;
    size = 24'(1 + tlen + ilen + payload);
    f.push_back(8'h00);
    for (int i = 0; i < 3; i++) f.push_back(size[8*i +: 8]);
    for (int i = 0; i < 4; i++) f.push_back(rfhc_pkg::MAGIC_WORD[8*i +: 8]);
    f.push_back(8'(((tlen - 1) << rfhc_pkg::TYPE_LEN_LSB) |
                   ((ilen - 1) << rfhc_pkg::ID_LEN_LSB) | $urandom_range(0, 3)));
    for (int i = 0; i < tlen; i++) f.push_back(tval[8*i +: 8]);
    for (int i = 0; i < ilen; i++) f.push_back(ival[8*i +: 8]);
    repeat (payload) f.push_back(8'($urandom));
    return f;
  endfunction

  // Mostly well-formed frames, some damaged or cut short, a few pure noise.
  function automatic frame_t make_random_frame();
    frame_t      f;
    int          kind;
    int          tlen;
    int          ilen;
    int          payload;
    logic [63:0] tval;
    logic [63:0] ival;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 24)) f.push_back(8'($urandom));
      return f;
    end
    if ($urandom_range(0, 1) == 1) begin
      tval = want_message_type;
      tlen = $urandom_range(8, bytes_needed(tval));
    end else begin
      tlen = $urandom_range(1, 8);
      tval = low_bytes(random_word(), tlen);
    end
    if ($urandom_range(0, 1) == 1) begin
      ival = want_request_id;
      ilen = $urandom_range(8, bytes_needed(ival));
    end else begin
      ilen = $urandom_range(1, 8);
      ival = low_bytes(random_word(), ilen);
    end
    payload = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
    f = make_frame(tlen, ilen, tval, ival, payload);
    if (kind >= 76) begin
      f = f[0:$urandom_range(0, f.size() - 2)];
    end else if (kind >= 66) begin
      f[$urandom_range(1, 3)] ^= 8'(1 << $urandom_range(0, 7));
    end else if (kind >= 56) begin
      f[$urandom_range(0, 8)] ^= 8'($urandom_range(1, 255));
    end
    return f;
  endfunction

  function automatic logic [63:0] pick_reg_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return low_bytes(random_word(), $urandom_range(1, 8));
    endcase
  endfunction

  // Send one byte, then maybe pause when the current burst runs out.
  task automatic send_byte(input logic [7:0] b, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    absorb_frame_byte(b, last);
    bytes_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_frame(input frame_t f);
    for (int i = 0; i < f.size(); i++) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic stream_idle();
    s_axis_tvalid <= 1'b0;
  endtask

  // Let every outstanding result drain before touching the registers.
  task automatic wait_idle();
    stream_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [rfhc_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic [rfhc_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [63:0] value);
    logic [63:0] unused;
    wait_idle();
    apb_access(1'b1, addr, value, unused);
    if (addr == ADDR_REQUEST_ID) want_request_id = value;
    else want_message_type = value;
  endtask

  task automatic cfg_read(input logic [rfhc_pkg::CFG_ADDR_W-1:0] addr);
    logic [63:0] value;
    apb_access(1'b0, addr, '0, value);
    compare_field(addr == ADDR_REQUEST_ID ? "expected_request_id" : "expected_message_type",
                  addr == ADDR_REQUEST_ID ? want_request_id : want_message_type, value);
  endtask

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Reset values, then a write and read-back of each register.
  task automatic test_register_access();
    cfg_read(ADDR_REQUEST_ID);
    cfg_read(ADDR_MESSAGE_TYPE);
    cfg_write(ADDR_REQUEST_ID, 64'h0123_4567_89AB_CDEF);
    cfg_write(ADDR_MESSAGE_TYPE, 64'hFEDC_BA98_7654_3210);
    cfg_read(ADDR_REQUEST_ID);
    cfg_read(ADDR_MESSAGE_TYPE);
    cfg_write(ADDR_REQUEST_ID, rfhc_pkg::REQUEST_ID_RESET);
    cfg_write(ADDR_MESSAGE_TYPE, rfhc_pkg::MESSAGE_TYPE_RESET);
  endtask

  // One frame for each status and each short-frame case, with the reset settings.
  task automatic test_directed_frames();
    frame_t f;
    f = '{8'hFF};
    send_frame(f);
    // Size field complete but the frame head is not.
    f = '{8'h00, 8'hFF, 8'hFF, 8'hFF};
    send_frame(f);
    f = make_frame(1, 1, 64'd90, 64'd0, 0);
    f[0] = 8'hFF;
    send_frame(f[0:7]);
    f = make_frame(1, 1, 64'd90, 64'd0, 0);
    f[7] ^= 8'h80;
    send_frame(f[0:7]);
    // Bad version and bad magic together: the version check comes first.
    f = make_frame(1, 1, 64'd90, 64'd0, 0);
    f[0] = 8'h01;
    f[4] = 8'h00;
    send_frame(f);
    // Frame head only, then descriptor only: both truncated.
    f = make_frame(1, 1, 64'd90, 64'd0, 0);
    send_frame(f[0:7]);
    send_frame(f[0:8]);
    // Longest variable header cut short.
    f = make_frame(8, 8, '1, '1, 0);
    send_frame(f[0:19]);
    send_frame(make_frame(1, 1, 64'd90, 64'd0, 0));
    f = make_frame(1, 1, 64'd90, 64'd0, 0);
    f[1] = f[1] + 8'd1;
    send_frame(f);
    // Frame longer than its declared size.
    f = make_frame(1, 1, 64'd90, 64'd0, 2);
    f.push_back(8'h00);
    send_frame(f);
    send_frame(make_frame(1, 2, 64'd90, 64'h0100, 0));
    send_frame(make_frame(1, 1, 64'd91, 64'd0, 0));
    send_frame(make_frame(8, 8, 64'd90, 64'd0, 5));
  endtask

  // All-ones and all-zeros settings with matching and non-matching frames.
  task automatic test_config_extremes();
    cfg_write(ADDR_MESSAGE_TYPE, '1);
    cfg_write(ADDR_REQUEST_ID, '1);
    cfg_read(ADDR_MESSAGE_TYPE);
    cfg_read(ADDR_REQUEST_ID);
    send_frame(make_frame(8, 8, '1, '1, 0));
    send_frame(make_frame(8, 8, '1, 64'hFFFF_FFFF_FFFF_FFFE, 2));
    send_frame(make_frame(7, 8, '1, '1, 1));
    cfg_write(ADDR_MESSAGE_TYPE, '0);
    cfg_write(ADDR_REQUEST_ID, '0);
    send_frame(make_frame(8, 1, 64'd0, 64'd0, 1));
    send_frame(make_frame(1, 8, 64'd0, 64'd0, 0));
  endtask

  // Random frames until the byte budget is used, with the settings perhaps changed every fourth frame.
  task automatic test_random_frames();
    int frames;
    frames = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (frames % 4 == 0) begin
        if ($urandom_range(0, 2) != 0) cfg_write(ADDR_MESSAGE_TYPE, pick_reg_value());
        if ($urandom_range(0, 2) != 0) cfg_write(ADDR_REQUEST_ID, pick_reg_value());
      end
      send_frame(make_random_frame());
      frames++;
    end
  endtask

  // Receiver back-pressure: the stall pattern changes every so often.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_left % 16) < 10;
      endcase
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    rfhc_pkg::result_t got;
    rfhc_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = rfhc_pkg::result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        $error("result with no frame waiting for it: 0x%0h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("header_length", 64'(want.header_length), 64'(got.header_length));
        compare_field("message_type", want.message_type, got.message_type);
        compare_field("request_id", want.request_id, got.request_id);
        compare_field("message_size", 64'(want.message_size), 64'(got.message_size));
      end
    end
  end

  // Watchdog on cycles with no transaction on any port.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed_frames();
    test_config_extremes();
    test_random_frames();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
